[hw/rtl/pnl_filt_pkg.sv]
// ----------------------------------------------------------------------------
// pnl_filt_pkg
// Shared types, constants and helpers of the periodic neighbor list filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pnl_filt_pkg;

   // default parameter values
   localparam int NUM_TYPES_DEF         = 4;
   localparam int MAX_NEIGHBORS_DEF     = 64;
   localparam int MAX_ATOMS_DEF         = 4096;
   localparam int MAX_CELLS_PER_DIM_DEF = 2;

   // field widths
   localparam int POS_W    = 32;
   localparam int IDX_W    = 12;
   localparam int TYPE_W   = 2;
   localparam int NUM_W    = 13;
   localparam int SLOT_W   = 6;
   localparam int REG_W    = 64;
   localparam int ROW_W    = 63;
   localparam int CELLS_W  = 9;
   localparam int CUT_W    = 16;
   localparam int CSR_IDX_W = 3;

   // arithmetic widths
   localparam int ENT_W  = 21;  // one box / inverse entry
   localparam int CNT_W  = 3;   // cell count and image counter
   localparam int SH_W   = 26;  // lattice shift, Q.10
   localparam int DIFF_W = 35;  // offset, Q.16
   localparam int SRAW_W = 58;  // fractional coordinate before wrap, Q.35
   localparam int FRAC   = 35;
   localparam int SW_W   = 36;  // wrapped fractional coordinate
   localparam int EB_W   = 24;  // expanded box entry
   localparam int V_W    = 64;  // back mapping, Q.45
   localparam int RND_SH = 29;
   localparam int RD_W   = 35;  // rounded offset, Q.16
   localparam int DIST_W = 64;
   localparam int CUT_SH = 24;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 120;

   typedef enum logic [0:0] {
      OP_CENTER    = 1'b0,
      OP_CANDIDATE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOX_X     = 3'd0,
      REG_BOX_Y     = 3'd1,
      REG_BOX_Z     = 3'd2,
      REG_INV_A     = 3'd3,
      REG_INV_B     = 3'd4,
      REG_INV_C     = 3'd5,
      REG_CUTOFF    = 3'd6,
      REG_CELLS     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic       load_center;
      logic       load_cand;
      logic       calc_diff;
      logic       calc_frac;
      logic       calc_wrap;
      logic       calc_back;
      logic       calc_sq;
      logic [1:0] row;
      logic       step_img;
      logic       take_hit;
      logic       push_pend;
      logic       push_last;
   } cmd_type;

   typedef struct packed {
      logic cand_ok;
      logic skip_img;
      logic img_last;
      logic hit;
      logic pend_valid;
      logic out_free;
   } status_type;

   // Wrap a Q.35 coordinate into [-0.5, 0.5].
   function automatic logic signed [SW_W-1:0] wrap_frac(input logic signed [SRAW_W-1:0] s);
      localparam logic signed [SRAW_W-1:0] HalfQ    = SRAW_W'(64'd1 << (FRAC - 1));
      localparam logic signed [SRAW_W-1:0] NegHalfQ = -HalfQ;
      logic [FRAC-1:0]         r;
      logic signed [SW_W-1:0]  rs;
      logic signed [SW_W-1:0]  rm;
      logic                    r_ge;
      logic                    r_gt;
      logic signed [SW_W-1:0]  res;
      r    = s[FRAC-1:0];
      rs   = signed'({1'b0, r});
      rm   = signed'({1'b1, r});
      r_ge = r[FRAC-1];
      r_gt = r[FRAC-1] && (|r[FRAC-2:0]);
      if (s < NegHalfQ) begin
         res = r_ge ? rm : rs;
      end else if (s > HalfQ) begin
         res = r_gt ? rm : rs;
      end else begin
         res = SW_W'(s);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/pnl_filt_ctrl.sv]
// ----------------------------------------------------------------------------
// pnl_filt_ctrl
// Sequencer: walks each candidate through the image shifts, one row of the
// matrix work per cycle, and orders hits into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnl_filt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic                    req_op,
   input  wire pnl_filt_pkg::status_type sts,
   output pnl_filt_pkg::cmd_type        cmd
);
   import pnl_filt_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP  = 8'b0000_0010,
      ST_DIFF   = 8'b0000_0100,
      ST_FRAC   = 8'b0000_1000,
      ST_WRAP   = 8'b0001_0000,
      ST_BACK   = 8'b0010_0000,
      ST_SQR    = 8'b0100_0000,
      ST_DECIDE = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic       finish_ff, finish_in;   // all images done, draining pending hit
   logic [1:0] row_ff, row_in;

   always_comb begin
      state_in   = state_ff;
      finish_in  = finish_ff;
      row_in     = row_ff;
      cmd        = '0;
      cmd.row    = row_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (finish_ff) begin
               if (!sts.pend_valid) begin
                  finish_in = 1'b0;
               end else if (sts.out_free) begin
                  cmd.push_pend = 1'b1;
                  cmd.push_last = 1'b1;
                  finish_in     = 1'b0;
               end
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  if (op_type'(req_op) == OP_CENTER) begin
                     cmd.load_center = 1'b1;
                  end else begin
                     cmd.load_cand = 1'b1;
                     state_in      = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            state_in = sts.cand_ok ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            if (sts.skip_img) begin
               if (sts.img_last) begin
                  state_in  = ST_IDLE;
                  finish_in = 1'b1;
               end else begin
                  cmd.step_img = 1'b1;
               end
            end else begin
               cmd.calc_diff = 1'b1;
               row_in        = 2'd0;
               state_in      = ST_FRAC;
            end
         end
         ST_FRAC: begin
            cmd.calc_frac = 1'b1;
            row_in        = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
            if (row_ff == 2'd2) state_in = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.calc_wrap = 1'b1;
            state_in      = ST_BACK;
         end
         ST_BACK: begin
            cmd.calc_back = 1'b1;
            row_in        = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
            if (row_ff == 2'd2) state_in = ST_SQR;
         end
         ST_SQR: begin
            cmd.calc_sq = 1'b1;
            row_in      = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
            if (row_ff == 2'd2) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
               if (sts.hit) begin
                  cmd.take_hit  = 1'b1;
                  cmd.push_pend = sts.pend_valid;
               end
               if (sts.img_last) begin
                  state_in  = ST_IDLE;
                  finish_in = 1'b1;
               end else begin
                  cmd.step_img = 1'b1;
                  state_in     = ST_DIFF;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         finish_ff <= 1'b0;
         row_ff    <= 2'd0;
      end else begin
         state_ff  <= state_in;
         finish_ff <= finish_in;
         row_ff    <= row_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE) && !finish_ff)
      else $error("input taken while busy");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff != 2'd3)
      else $error("row counter out of range");
   a_frac_to_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAC) && (row_ff == 2'd2) |=> (state_ff == ST_WRAP))
      else $error("fraction rows not completed");
`endif

endmodule

`default_nettype wire

[hw/rtl/pnl_filt_dp.sv]
// ----------------------------------------------------------------------------
// pnl_filt_dp
// Datapath: configuration registers, center state, image counters, the
// fixed-point offset math, per-type slot counters and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pnl_filt_dp #(
   parameter int NUM_TYPES         = pnl_filt_pkg::NUM_TYPES_DEF,
   parameter int MAX_NEIGHBORS     = pnl_filt_pkg::MAX_NEIGHBORS_DEF,
   parameter int MAX_ATOMS         = pnl_filt_pkg::MAX_ATOMS_DEF,
   parameter int MAX_CELLS_PER_DIM = pnl_filt_pkg::MAX_CELLS_PER_DIM_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   input  wire logic [pnl_filt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pnl_filt_pkg::REG_W-1:0]         csr_data,
   input  wire logic [pnl_filt_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [pnl_filt_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                        rsp_tuser,
   output logic                                        rsp_tlast,
   input  wire pnl_filt_pkg::cmd_type                  cmd,
   output pnl_filt_pkg::status_type                    sts
);
   import pnl_filt_pkg::*;

   localparam int TCNT_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int TI_W   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int ATOM_W = $clog2(MAX_ATOMS + 1) + 1;

   // configuration
   logic [ROW_W-1:0]   box_ff [3];
   logic [ROW_W-1:0]   inv_ff [3];
   logic [REG_W-1:0]   cut_reg_ff;
   logic [CELLS_W-1:0] cells_ff;

   // center and candidate
   logic signed [POS_W-1:0] center_ff [3];
   logic [IDX_W-1:0]        center_num_ff;
   logic signed [POS_W-1:0] pos_ff [3];
   logic [IDX_W-1:0]        idx_ff;
   logic [TYPE_W-1:0]       typ_ff;
   logic [CNT_W-1:0]        n_ff [3];
   logic [CNT_W-1:0]        img_ff [3];
   logic signed [EB_W-1:0]  eb_ff [3][3];
   logic [TCNT_W-1:0]       tcnt_ff [NUM_TYPES];

   // per-image math
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [SRAW_W-1:0] sraw_ff [3];
   logic signed [SW_W-1:0]   s_ff [3];
   logic signed [RD_W-1:0]   rd_ff [3];
   logic [DIST_W-1:0]        dist_ff;

   // pending hit and output register
   logic               pend_valid_ff;
   logic [NUM_W-1:0]   pend_num_ff;
   logic [TYPE_W-1:0]  pend_typ_ff;
   logic [SLOT_W-1:0]  pend_slot_ff;
   logic [POS_W-1:0]   pend_d_ff [3];
   logic               pend_ovf_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_ovf_ff;
   logic               rsp_last_ff;

   logic signed [ENT_W-1:0] req_box [3][3];
   logic [CNT_W-1:0]        req_n [3];
   logic signed [DIFF_W-1:0] diff_new [3];
   logic signed [SRAW_W-1:0] frac_sum;
   logic signed [V_W-1:0]    back_sum;
   logic signed [V_W-1:0]    back_rnd;
   logic [RD_W-1:0]          mag;
   logic [DIST_W-1:0]        sq;
   logic [TI_W-1:0]          tidx;
   logic [CUT_W-1:0]         cut_sel;
   logic                     out_free;
   logic                     cnt_full;

   function automatic logic signed [ENT_W-1:0] ent(input logic [ROW_W-1:0] row, input int j);
      return signed'(row[ENT_W*j +: ENT_W]);
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            req_box[r][j] = ent(box_ff[r], j);
         end
         req_n[r] = (cells_ff[CNT_W*r +: CNT_W] > CNT_W'(MAX_CELLS_PER_DIM)) ?
                    CNT_W'(MAX_CELLS_PER_DIM) : cells_ff[CNT_W*r +: CNT_W];
      end
   end

   // offset of the current image: candidate + lattice shift - center
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         logic signed [SH_W-1:0] sh;
         sh = SH_W'(req_box[r][0]) * SH_W'(signed'({1'b0, img_ff[0]}))
            + SH_W'(req_box[r][1]) * SH_W'(signed'({1'b0, img_ff[1]}))
            + SH_W'(req_box[r][2]) * SH_W'(signed'({1'b0, img_ff[2]}));
         diff_new[r] = DIFF_W'(pos_ff[r]) + (DIFF_W'(sh) <<< 6) - DIFF_W'(center_ff[r]);
      end
   end

   // one matrix row per cycle
   always_comb begin
      logic signed [SRAW_W-1:0] p0, p1, p2;
      logic signed [V_W-1:0]    q0, q1, q2;
      logic signed [RD_W-1:0]   rsel;
      p0 = ent(inv_ff[cmd.row], 0) * d_ff[0];
      p1 = ent(inv_ff[cmd.row], 1) * d_ff[1];
      p2 = ent(inv_ff[cmd.row], 2) * d_ff[2];
      frac_sum = p0 + p1 + p2;
      q0 = eb_ff[cmd.row][0] * s_ff[0];
      q1 = eb_ff[cmd.row][1] * s_ff[1];
      q2 = eb_ff[cmd.row][2] * s_ff[2];
      back_sum = q0 + q1 + q2;
      back_rnd = (back_sum + (V_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
      rsel = rd_ff[cmd.row];
      mag  = rsel[RD_W-1] ? RD_W'(-rsel) : RD_W'(rsel);
      sq   = DIST_W'(mag) * DIST_W'(mag);
   end

   assign tidx     = TI_W'(typ_ff);
   assign cut_sel  = cut_reg_ff[CUT_W*typ_ff +: CUT_W];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_full = (tcnt_ff[tidx] >= TCNT_W'(MAX_NEIGHBORS));

   always_comb begin
      sts.cand_ok    = (5'(typ_ff) < 5'(NUM_TYPES)) && (ATOM_W'(idx_ff) < ATOM_W'(MAX_ATOMS))
                       && (n_ff[0] != '0) && (n_ff[1] != '0) && (n_ff[2] != '0);
      sts.skip_img   = (img_ff[0] == '0) && (img_ff[1] == '0) && (img_ff[2] == '0)
                       && (idx_ff == center_num_ff);
      sts.img_last   = (img_ff[0] == n_ff[0] - CNT_W'(1)) && (img_ff[1] == n_ff[1] - CNT_W'(1))
                       && (img_ff[2] == n_ff[2] - CNT_W'(1));
      sts.hit        = dist_ff < (DIST_W'(cut_sel) << CUT_SH);
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   // configuration and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            box_ff[r]    <= '0;
            inv_ff[r]    <= '0;
            center_ff[r] <= '0;
         end
         cut_reg_ff    <= '0;
         cells_ff      <= CELLS_W'(73);
         center_num_ff <= '0;
         for (int t = 0; t < NUM_TYPES; t++) tcnt_ff[t] <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_BOX_X:  box_ff[0]  <= csr_data[ROW_W-1:0];
               REG_BOX_Y:  box_ff[1]  <= csr_data[ROW_W-1:0];
               REG_BOX_Z:  box_ff[2]  <= csr_data[ROW_W-1:0];
               REG_INV_A:  inv_ff[0]  <= csr_data[ROW_W-1:0];
               REG_INV_B:  inv_ff[1]  <= csr_data[ROW_W-1:0];
               REG_INV_C:  inv_ff[2]  <= csr_data[ROW_W-1:0];
               REG_CUTOFF: cut_reg_ff <= csr_data;
               REG_CELLS:  cells_ff   <= csr_data[CELLS_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load_center) begin
            center_ff[0]  <= signed'(req_tdata[0 +: POS_W]);
            center_ff[1]  <= signed'(req_tdata[POS_W +: POS_W]);
            center_ff[2]  <= signed'(req_tdata[2*POS_W +: POS_W]);
            center_num_ff <= req_tdata[3*POS_W +: IDX_W];
            for (int t = 0; t < NUM_TYPES; t++) tcnt_ff[t] <= '0;
         end
         if (cmd.take_hit && !cnt_full) begin
            tcnt_ff[tidx] <= tcnt_ff[tidx] + TCNT_W'(1);
         end
         if (cmd.take_hit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.push_pend) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.push_pend) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_cand) begin
         pos_ff[0] <= signed'(req_tdata[0 +: POS_W]);
         pos_ff[1] <= signed'(req_tdata[POS_W +: POS_W]);
         pos_ff[2] <= signed'(req_tdata[2*POS_W +: POS_W]);
         idx_ff    <= req_tdata[3*POS_W +: IDX_W];
         typ_ff    <= req_tdata[3*POS_W+IDX_W +: TYPE_W];
         for (int j = 0; j < 3; j++) begin
            n_ff[j]   <= req_n[j];
            img_ff[j] <= '0;
            for (int r = 0; r < 3; r++) begin
               eb_ff[r][j] <= EB_W'(req_box[r][j]) * EB_W'(signed'({1'b0, req_n[j]}));
            end
         end
      end
      if (cmd.step_img) begin
         if (img_ff[2] != n_ff[2] - CNT_W'(1)) begin
            img_ff[2] <= img_ff[2] + CNT_W'(1);
         end else begin
            img_ff[2] <= '0;
            if (img_ff[1] != n_ff[1] - CNT_W'(1)) begin
               img_ff[1] <= img_ff[1] + CNT_W'(1);
            end else begin
               img_ff[1] <= '0;
               img_ff[0] <= img_ff[0] + CNT_W'(1);
            end
         end
      end
      if (cmd.calc_diff) begin
         for (int r = 0; r < 3; r++) d_ff[r] <= diff_new[r];
      end
      if (cmd.calc_frac) sraw_ff[cmd.row] <= frac_sum;
      if (cmd.calc_wrap) begin
         for (int r = 0; r < 3; r++) s_ff[r] <= wrap_frac(sraw_ff[r]);
      end
      if (cmd.calc_back) rd_ff[cmd.row] <= RD_W'(back_rnd);
      if (cmd.calc_sq) dist_ff <= ((cmd.row == 2'd0) ? DIST_W'(0) : dist_ff) + sq;
      if (cmd.take_hit) begin
         pend_num_ff  <= NUM_W'(idx_ff) + NUM_W'(1);
         pend_typ_ff  <= typ_ff;
         pend_slot_ff <= cnt_full ? SLOT_W'(0) : SLOT_W'(tcnt_ff[tidx]);
         pend_ovf_ff  <= cnt_full;
         for (int r = 0; r < 3; r++) pend_d_ff[r] <= rd_ff[r][POS_W-1:0];
      end
      if (cmd.push_pend) begin
         rsp_data_ff <= {3'b000, pend_d_ff[2], pend_d_ff[1], pend_d_ff[0],
                         pend_slot_ff, pend_typ_ff, pend_num_ff};
         rsp_ovf_ff  <= pend_ovf_ff;
         rsp_last_ff <= cmd.push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push_pend |-> out_free)
      else $error("result register overwritten");
   a_hit_drains_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.take_hit && pend_valid_ff |-> cmd.push_pend)
      else $error("pending hit lost");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.take_hit |-> tcnt_ff[tidx] <= TCNT_W'(MAX_NEIGHBORS))
      else $error("type counter past limit");
`endif

endmodule

`default_nettype wire

[hw/rtl/periodic_neighbor_list_filter.sv]
// ----------------------------------------------------------------------------
// periodic_neighbor_list_filter
// Minimum-image neighbor filter for a periodic cell, Q16.16 positions.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: pos_x,pos_y,pos_z,atom_index,
//          |     |                       |        atom_type; tuser: op
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: neighbor_number,neighbor_type,
//          |     |                       |        slot,delta_x/y/z; tuser: overflow;
//          |     |                       |        tlast: last
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
//  Center transaction: loaded while idle. Candidate: setup, then per tested
//  image diff, 3 fraction rows, wrap, 3 back rows, 3 square rows, decide;
//  a skipped image only steps the image counter. The last hit of a candidate
//  drains at the end. Rows share the row multipliers. Up to 8 images at default.
//  Reset: synchronous, active high; cell_counts resets to 1,1,1.
//  A stalled rsp side holds the sequencer when a second hit is ready or when
//  the last hit of a candidate waits to drain.
//  csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_neighbor_list_filter #(
   parameter int NUM_TYPES         = pnl_filt_pkg::NUM_TYPES_DEF,
   parameter int MAX_NEIGHBORS     = pnl_filt_pkg::MAX_NEIGHBORS_DEF,
   parameter int MAX_ATOMS         = pnl_filt_pkg::MAX_ATOMS_DEF,
   parameter int MAX_CELLS_PER_DIM = pnl_filt_pkg::MAX_CELLS_PER_DIM_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [107:96] atom_index,
   // [109:108] atom_type, rest zero
   input  wire logic [pnl_filt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [12:0] neighbor_number, [14:13] neighbor_type, [20:15] slot,
   // [52:21] delta_x, [84:53] delta_y, [116:85] delta_z, rest zero
   output logic [pnl_filt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] overflow
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pnl_filt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pnl_filt_pkg::REG_W-1:0]      csr_data
);
   import pnl_filt_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   // sequencer: owns the input handshake
   pnl_filt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: config, math, counters and result register
   pnl_filt_dp #(
      .NUM_TYPES         (NUM_TYPES),
      .MAX_NEIGHBORS     (MAX_NEIGHBORS),
      .MAX_ATOMS         (MAX_ATOMS),
      .MAX_CELLS_PER_DIM (MAX_CELLS_PER_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire
